FILE: design/fsuhd_pkg.sv
// Shared constants and types for the frame sample unpacker and header decoder.
package fsuhd_pkg;

  localparam int FRAME_SAMPLES = 256;
  localparam int HEADER_BYTES  = 10;

  // Sample counter holds 0..FRAME_SAMPLES inclusive
  localparam int SD_W = $clog2(FRAME_SAMPLES + 1);
  localparam logic [SD_W-1:0] FRAME_FULL = SD_W'(FRAME_SAMPLES);

  // Header byte slots
  localparam logic [3:0] HDR_YEAR_STATION = 4'd0;
  localparam logic [3:0] HDR_MSEC_0       = 4'd1;
  localparam logic [3:0] HDR_MSEC_1       = 4'd2;
  localparam logic [3:0] HDR_MSEC_2       = 4'd3;
  localparam logic [3:0] HDR_MSEC_DAY     = 4'd4;
  localparam logic [3:0] HDR_DAY_DRIFT    = 4'd5;
  localparam logic [3:0] HDR_DRIFT_HI     = 4'd6;
  localparam logic [3:0] HDR_CONTROL      = 4'd7;
  localparam logic [3:0] HDR_DELAY        = 4'd8;
  localparam logic [3:0] HDR_FLAGS        = 4'd9;
  localparam logic [3:0] HDR_DONE         = 4'(HEADER_BYTES);

  // Result kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_HEADER = 1'b1;

  // Output queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic        kind;
    logic [4:0]  sample;
    logic        last;
    logic [3:0]  year_digit;
    logic [3:0]  station;
    logic [26:0] time_msec;
    logic [8:0]  day_number;
    logic [11:0] drift;
    logic [7:0]  control_byte;
    logic [7:0]  digitize_delay;
    logic [7:0]  status_flags;
  } fsuhd_res_t;

endpackage

FILE: design/fsuhd_if.sv
// Valid/ready channel interfaces for input bytes and results.
interface fsuhd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;
  logic       header_restart;

  modport source (output valid, data_byte, frame_start, header_restart, input ready);
  modport sink   (input valid, data_byte, frame_start, header_restart, output ready);
endinterface

interface fsuhd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [4:0]  sample;
  logic        last;
  logic [3:0]  year_digit;
  logic [3:0]  station;
  logic [26:0] time_msec;
  logic [8:0]  day_number;
  logic [11:0] drift;
  logic [7:0]  control_byte;
  logic [7:0]  digitize_delay;
  logic [7:0]  status_flags;

  modport source (output valid, kind, sample, last, year_digit, station, time_msec,
                  day_number, drift, control_byte, digitize_delay, status_flags,
                  input ready);
  modport sink   (input valid, kind, sample, last, year_digit, station, time_msec,
                  day_number, drift, control_byte, digitize_delay, status_flags,
                  output ready);
endinterface

FILE: design/frame_sample_unpack_header_decode.sv
// Top level: minor-frame byte unpacker into 5-bit samples with aux header assembly.
// A byte passes through the input register, then the 4-deep result queue.
// Throughput: one byte per cycle while the queue has room for two results; the single
//   result port sets the sustained rate.
// Reset (rst_n, sync, active low) clears all unpack/header state and both buffers.
module frame_sample_unpack_header_decode
  import fsuhd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  fsuhd_in_if.sink      in_ch,
  fsuhd_out_if.source   out_ch
);

  // ---------------------------------------------------------------
  // Input register: one held transaction
  // ---------------------------------------------------------------
  logic       pipe_v_r, pipe_v_nxt;
  logic [7:0] pipe_byte_r;
  logic       pipe_start_r;
  logic       pipe_restart_r;

  // ---------------------------------------------------------------
  // Unpack / header state
  // ---------------------------------------------------------------
  logic [3:0]      lb_r, lb_nxt;        // leftover bits, right-aligned
  logic [2:0]      lc_r, lc_nxt;        // leftover count
  logic [SD_W-1:0] sd_r, sd_nxt;        // samples this frame
  logic [3:0]      hidx_r, hidx_nxt;    // next header byte slot
  logic [7:0]      ys_r, ys_nxt;
  logic [26:0]     msec_r, msec_nxt;
  logic [8:0]      day_r, day_nxt;
  logic [11:0]     drift_r, drift_nxt;
  logic [7:0]      ctrl_r, ctrl_nxt;
  logic [7:0]      dly_r, dly_nxt;

  // ---------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------
  fsuhd_res_t        q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] q_cnt_r, q_cnt_nxt;

  logic in_acc, pop, proc;
  logic [QCNT_W-1:0] cnt_after_pop;

  assign in_acc        = in_ch.valid && in_ch.ready;
  assign pop           = out_ch.valid && out_ch.ready;
  assign cnt_after_pop = q_cnt_r - QCNT_W'(pop);
  // Process the held byte only if two result slots are free after this cycle's pop
  assign proc          = pipe_v_r && (cnt_after_pop <= QCNT_W'(QDEPTH - 2));
  assign in_ch.ready   = !pipe_v_r || proc;

  always_comb begin
    pipe_v_nxt = pipe_v_r;
    if (in_acc) begin
      pipe_v_nxt = 1'b1;
    end else if (proc) begin
      pipe_v_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------
  // Per-byte logic
  // ---------------------------------------------------------------
  logic [3:0]      hidx_eff;
  logic [11:0]     acc;
  logic [3:0]      nb1, nb2;
  logic            take2;
  logic [SD_W-1:0] sd_inc, sd_new;
  logic [2:0]      lc_keep;
  logic [4:0]      keep_mask;
  logic [3:0]      tens;
  logic [1:0]      push_n;
  fsuhd_res_t      res0, res1;

  always_comb begin
    lb_nxt    = lb_r;
    lc_nxt    = lc_r;
    sd_nxt    = sd_r;
    hidx_nxt  = hidx_r;
    ys_nxt    = ys_r;
    msec_nxt  = msec_r;
    day_nxt   = day_r;
    drift_nxt = drift_r;
    ctrl_nxt  = ctrl_r;
    dly_nxt   = dly_r;
    push_n    = 2'd0;
    res0      = '0;
    res1      = '0;

    hidx_eff  = pipe_restart_r ? HDR_YEAR_STATION : hidx_r;
    tens      = dly_r[7:4];

    // Payload path: bits MSB-first; 8..12 bits available, first sample always fits
    acc       = {lb_r, pipe_byte_r};
    nb1       = 4'({1'b0, lc_r} + 4'd3);   // (lc + 8) - 5
    nb2       = nb1 - 4'd5;
    sd_inc    = sd_r + SD_W'(1);
    take2     = (nb1 >= 4'd5) && (sd_inc < FRAME_FULL);
    sd_new    = take2 ? (sd_r + SD_W'(2)) : sd_inc;
    lc_keep   = take2 ? nb2[2:0] : nb1[2:0];
    keep_mask = (5'd1 << lc_keep) - 5'd1;

    if (proc) begin
      if (pipe_start_r) begin
        lb_nxt = '0;
        lc_nxt = '0;
        sd_nxt = '0;
        hidx_nxt = hidx_eff;
        unique case (hidx_eff)
          HDR_YEAR_STATION: ys_nxt = pipe_byte_r;
          HDR_MSEC_0:       msec_nxt[7:0]   = pipe_byte_r;
          HDR_MSEC_1:       msec_nxt[15:8]  = pipe_byte_r;
          HDR_MSEC_2:       msec_nxt[23:16] = pipe_byte_r;
          HDR_MSEC_DAY: begin
            msec_nxt[26:24] = pipe_byte_r[2:0];
            day_nxt[4:0]    = pipe_byte_r[7:3];
          end
          HDR_DAY_DRIFT: begin
            drift_nxt[3:0] = pipe_byte_r[7:4];
            day_nxt[8:5]   = pipe_byte_r[3:0];
          end
          HDR_DRIFT_HI:     drift_nxt[11:4] = pipe_byte_r;
          HDR_CONTROL:      ctrl_nxt = pipe_byte_r;
          HDR_DELAY:        dly_nxt  = pipe_byte_r;
          HDR_FLAGS: begin
            res0.kind           = KIND_HEADER;
            res0.last           = 1'b1;
            res0.year_digit     = ys_r[7:4];
            res0.station        = ys_r[3:0];
            res0.time_msec      = msec_r;
            res0.day_number     = day_r;
            res0.drift          = drift_r;
            res0.control_byte   = ctrl_r;
            // tens*10 + units, BCD digits taken as binary
            res0.digitize_delay = 8'({tens, 3'b000}) + 8'({tens, 1'b0}) + 8'(dly_r[3:0]);
            res0.status_flags   = pipe_byte_r;
            push_n = 2'd1;
          end
          default: ;  // header complete, extra aux bytes ignored
        endcase
        if (hidx_eff < HDR_FLAGS) begin
          hidx_nxt = hidx_eff + 4'd1;
        end else if (hidx_eff == HDR_FLAGS) begin
          hidx_nxt = HDR_DONE;
        end
      end else if (sd_r >= FRAME_FULL) begin
        // Frame full: drop byte
        lb_nxt = '0;
        lc_nxt = '0;
      end else begin
        res0.kind   = KIND_SAMPLE;
        res0.sample = 5'(acc >> nb1);
        res1.kind   = KIND_SAMPLE;
        res1.sample = 5'(acc >> nb2);
        res1.last   = 1'b1;
        res0.last   = !take2;
        push_n      = take2 ? 2'd2 : 2'd1;
        sd_nxt      = sd_new;
        if (sd_new >= FRAME_FULL) begin
          lb_nxt = '0;
          lc_nxt = '0;
        end else begin
          lc_nxt = lc_keep;
          lb_nxt = acc[3:0] & keep_mask[3:0];
        end
      end
    end
  end

  assign q_cnt_nxt = cnt_after_pop + QCNT_W'(push_n);

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_v_r <= 1'b0;
      lb_r     <= '0;
      lc_r     <= '0;
      sd_r     <= '0;
      hidx_r   <= HDR_YEAR_STATION;
      ys_r     <= '0;
      msec_r   <= '0;
      day_r    <= '0;
      drift_r  <= '0;
      ctrl_r   <= '0;
      dly_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      pipe_v_r <= pipe_v_nxt;
      lb_r     <= lb_nxt;
      lc_r     <= lc_nxt;
      sd_r     <= sd_nxt;
      hidx_r   <= hidx_nxt;
      ys_r     <= ys_nxt;
      msec_r   <= msec_nxt;
      day_r    <= day_nxt;
      drift_r  <= drift_nxt;
      ctrl_r   <= ctrl_nxt;
      dly_r    <= dly_nxt;
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + QPTR_W'(pop);
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pipe_byte_r    <= in_ch.data_byte;
      pipe_start_r   <= in_ch.frame_start;
      pipe_restart_r <= in_ch.header_restart;
    end
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_r + QPTR_W'(1)] <= res1;
    end
  end

  // ---------------------------------------------------------------
  // Result port
  // ---------------------------------------------------------------
  fsuhd_res_t head;
  assign head = q_r[rd_ptr_r];

  assign out_ch.valid          = (q_cnt_r != '0);
  assign out_ch.kind           = head.kind;
  assign out_ch.sample         = head.sample;
  assign out_ch.last           = head.last;
  assign out_ch.year_digit     = head.year_digit;
  assign out_ch.station        = head.station;
  assign out_ch.time_msec      = head.time_msec;
  assign out_ch.day_number     = head.day_number;
  assign out_ch.drift          = head.drift;
  assign out_ch.control_byte   = head.control_byte;
  assign out_ch.digitize_delay = head.digitize_delay;
  assign out_ch.status_flags   = head.status_flags;

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  a_hidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hidx_r <= HDR_DONE)
    else $error("header index out of range");

  a_hdr_done: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && pipe_start_r && hidx_eff == HDR_FLAGS) |=> (hidx_r == HDR_DONE))
    else $error("header index not parked after header result");

  a_leftover: assert property (@(posedge clk) disable iff (!rst_n)
    lc_r <= 3'd4)
    else $error("leftover count too large");

  a_sd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sd_r <= FRAME_FULL)
    else $error("sample count past frame size");
`endif

endmodule
